>>> design/ttbs_pkg.sv
// ttbs_pkg: shared types and fixed constants for the tuple table binary search
// no dependencies; imported by ttbs_cmp and tuple_table_binary_search
`default_nettype none

package ttbs_pkg;

   // fixed field widths of the request and response transactions
   localparam int POS_W     = 8;
   localparam int LEN_W     = 3;
   localparam int CMP_LEN_W = 4;
   localparam int IN_ELEMS  = 4;
   localparam int NUM_POS   = 2 ** POS_W;

   // request kinds
   localparam logic REQ_STORE  = 1'b0;
   localparam logic REQ_SEARCH = 1'b1;

   // outcome of comparing a key tuple against one stored entry
   typedef struct packed {
      logic key_below;
      logic key_above;
   } cmp_result_type;

endpackage

`default_nettype wire

>>> design/tuple_table_binary_search.sv
// tuple_table_binary_search: store transaction answers through the output register
// search transaction: one probe per cycle (one read of the tuple memory plus a compare),
//    an empty range answers without a probe of the table
// one request in flight; the next is taken once the result sits in the output register
// reset (synchronous, active high) clears control only; the tuple memory needs no clearing
// depends on ttbs_pkg and ttbs_cmp
`default_nettype none

module tuple_table_binary_search #(
   parameter int TABLE_DEPTH   = 256,
   parameter int MAX_TUPLE_LEN = 4,
   parameter int ELEM_WIDTH    = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // request channel
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_type,
   input  wire logic [ttbs_pkg::POS_W-1:0] req_entry_index,
   input  wire logic [ttbs_pkg::LEN_W-1:0] req_tuple_length,
   input  wire logic [ELEM_WIDTH-1:0]      req_elem_zero,
   input  wire logic [ELEM_WIDTH-1:0]      req_elem_one,
   input  wire logic [ELEM_WIDTH-1:0]      req_elem_two,
   input  wire logic [ELEM_WIDTH-1:0]      req_elem_three,
   input  wire logic [ttbs_pkg::POS_W-1:0] req_range_low,
   input  wire logic [ttbs_pkg::POS_W-1:0] req_range_high,
   // response channel
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic                            rsp_found,
   output logic [ttbs_pkg::POS_W-1:0]      rsp_position,
   output logic                            rsp_was_write
);
   import ttbs_pkg::*;

   // only the first four elements can ever differ; the rest are zero on both sides
   localparam int CMP_ELEMS = (MAX_TUPLE_LEN < IN_ELEMS) ? MAX_TUPLE_LEN : IN_ELEMS;
   localparam int ADDR_W    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int KEY_W     = CMP_ELEMS * ELEM_WIDTH;
   localparam int WORD_W    = LEN_W + KEY_W;
   localparam int RNG_W     = POS_W + 1;   // one extra bit so lo can pass hi

   localparam logic [CMP_LEN_W-1:0] MAX_LEN = CMP_LEN_W'(MAX_TUPLE_LEN);

   // controller states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_HOLD   = 2'd2;

   // positions wrap modulo the table depth; worked out at elaboration
   typedef logic [ADDR_W-1:0] slot_tab_type [NUM_POS];

   function automatic slot_tab_type build_slot_tab();
      slot_tab_type t;
      for (int i = 0; i < NUM_POS; i++) begin
         t[i] = ADDR_W'(i % TABLE_DEPTH);
      end
      return t;
   endfunction

   localparam slot_tab_type SLOT_TAB = build_slot_tab();

   // tuple memory: one row per entry holds {length, elements}
   logic [WORD_W-1:0] tuple_mem [TABLE_DEPTH];
   logic [WORD_W-1:0] rd_word_ff;

   // control and search registers
   logic [1:0]           state_ff, state_in;
   logic [RNG_W-1:0]     lo_ff, lo_in;
   logic [RNG_W-1:0]     hi_ff, hi_in;
   logic [POS_W-1:0]     mid_ff, mid_in;
   logic [KEY_W-1:0]     key_ff;
   logic [CMP_LEN_W-1:0] key_len_ff;

   // output register and the result parked behind it
   logic             rsp_valid_ff;
   logic             rsp_found_ff;
   logic [POS_W-1:0] rsp_position_ff;
   logic             rsp_was_write_ff;
   logic             pend_found_ff;
   logic [POS_W-1:0] pend_position_ff;
   logic             pend_was_write_ff;

   // request side
   logic                 in_accept;
   logic [ELEM_WIDTH-1:0] in_elems [IN_ELEMS];
   logic [KEY_W-1:0]     in_key;
   logic [CMP_LEN_W-1:0] in_len_ext;
   logic [CMP_LEN_W-1:0] in_len_clamped;
   logic [RNG_W:0]       in_sum;
   logic [POS_W-1:0]     in_mid;

   // memory port
   logic              mem_wr;
   logic              mem_rd;
   logic [POS_W-1:0]  mem_pos;
   logic [ADDR_W-1:0] mem_addr;

   // probe step
   cmp_result_type       cmp;
   logic [RNG_W:0]       next_sum;
   logic                 out_free;
   logic                 fin;
   logic                 fin_found;
   logic [POS_W-1:0]     fin_position;
   logic                 fin_was_write;

   assign in_accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign in_elems[0] = req_elem_zero;
   assign in_elems[1] = req_elem_one;
   assign in_elems[2] = req_elem_two;
   assign in_elems[3] = req_elem_three;

   always_comb begin
      in_key = '0;
      for (int i = 0; i < CMP_ELEMS; i++) begin
         in_key[i*ELEM_WIDTH +: ELEM_WIDTH] = in_elems[i];
      end
   end

   // key length clamped once at entry, first probe at the middle of the range
   assign in_len_ext     = CMP_LEN_W'(req_tuple_length);
   assign in_len_clamped = (in_len_ext > MAX_LEN) ? MAX_LEN : in_len_ext;
   assign in_sum         = (RNG_W+1)'(req_range_low) + (RNG_W+1)'(req_range_high);
   assign in_mid         = in_sum[POS_W:1];

   // compare the key against the entry read for the current probe
   ttbs_cmp #(
      .MAX_TUPLE_LEN (MAX_TUPLE_LEN),
      .ELEM_WIDTH    (ELEM_WIDTH),
      .CMP_ELEMS     (CMP_ELEMS)
   ) u_cmp (
      .key_elems   (key_ff),
      .key_len     (key_len_ff),
      .entry_elems (rd_word_ff[KEY_W-1:0]),
      .entry_len   (rd_word_ff[WORD_W-1:KEY_W]),
      .result      (cmp)
   );

   // sequencing: accept, probe loop, finish into the output register or park
   always_comb begin
      state_in      = state_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      next_sum      = '0;
      mem_wr        = 1'b0;
      mem_rd        = 1'b0;
      mem_pos       = mid_ff;
      fin           = 1'b0;
      fin_found     = 1'b0;
      fin_position  = '0;
      fin_was_write = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (in_accept) begin
               priority if (req_type == REQ_STORE) begin
                  // store transaction writes the row and finishes without a search
                  mem_wr        = 1'b1;
                  mem_pos       = req_entry_index;
                  fin           = 1'b1;
                  fin_was_write = 1'b1;
               end else if (req_range_low > req_range_high) begin
                  // empty range is a miss without touching the table
                  fin = 1'b1;
               end else begin
                  lo_in    = RNG_W'(req_range_low);
                  hi_in    = RNG_W'(req_range_high);
                  mid_in   = in_mid;
                  mem_rd   = 1'b1;
                  mem_pos  = in_mid;
                  state_in = ST_SEARCH;
               end
            end
         end

         ST_SEARCH: begin
            priority if (!cmp.key_below && !cmp.key_above) begin
               fin          = 1'b1;
               fin_found    = 1'b1;
               fin_position = mid_ff;
            end else if (cmp.key_below && mid_ff == '0) begin
               // key below the entry at position zero: nothing left below
               fin = 1'b1;
            end else begin
               if (cmp.key_below) begin
                  hi_in = RNG_W'(mid_ff) - RNG_W'(1);
               end else begin
                  lo_in = RNG_W'(mid_ff) + RNG_W'(1);
               end
               next_sum = (RNG_W+1)'(lo_in) + (RNG_W+1)'(hi_in);
               if (lo_in <= hi_in) begin
                  mid_in  = next_sum[POS_W:1];
                  mem_rd  = 1'b1;
                  mem_pos = next_sum[POS_W:1];
               end else begin
                  fin = 1'b1;
               end
            end
         end

         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a finished transaction goes straight out if the output register is free, else it parks in ST_HOLD
      if (fin) begin
         state_in = out_free ? ST_IDLE : ST_HOLD;
      end
   end

   assign mem_addr = SLOT_TAB[mem_pos];

   // tuple memory: one write or one read per cycle, read data registered
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         tuple_mem[mem_addr] <= {req_tuple_length, in_key};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd) begin
         rd_word_ff <= tuple_mem[mem_addr];
      end
   end

   // search registers, key captured at accept
   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      if (in_accept) begin
         key_ff     <= in_key;
         key_len_ff <= in_len_clamped;
      end
   end

   // parked result while the output register is still held
   always_ff @(posedge clock) begin
      if (fin && !out_free) begin
         pend_found_ff     <= fin_found;
         pend_position_ff  <= fin_position;
         pend_was_write_ff <= fin_was_write;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (fin && out_free) begin
         rsp_found_ff     <= fin_found;
         rsp_position_ff  <= fin_position;
         rsp_was_write_ff <= fin_was_write;
      end else if (state_ff == ST_HOLD && out_free) begin
         rsp_found_ff     <= pend_found_ff;
         rsp_position_ff  <= pend_position_ff;
         rsp_was_write_ff <= pend_was_write_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if ((fin && out_free) || (state_ff == ST_HOLD && out_free)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_position  = rsp_position_ff;
   assign rsp_was_write = rsp_was_write_ff;

endmodule

`default_nettype wire

>>> design/ttbs_cmp.sv
// ttbs_cmp: lexicographic compare of a key tuple against a stored entry
// over the shorter of the two clamped lengths; depends on ttbs_pkg
`default_nettype none

module ttbs_cmp #(
   parameter int MAX_TUPLE_LEN = 4,
   parameter int ELEM_WIDTH    = 32,
   parameter int CMP_ELEMS     = 4
) (
   input  wire logic [CMP_ELEMS*ELEM_WIDTH-1:0] key_elems,
   input  wire logic [ttbs_pkg::CMP_LEN_W-1:0]  key_len,
   input  wire logic [CMP_ELEMS*ELEM_WIDTH-1:0] entry_elems,
   input  wire logic [ttbs_pkg::LEN_W-1:0]      entry_len,
   output ttbs_pkg::cmp_result_type             result
);
   import ttbs_pkg::*;

   localparam logic [CMP_LEN_W-1:0] MAX_LEN = CMP_LEN_W'(MAX_TUPLE_LEN);

   logic [CMP_LEN_W-1:0] entry_len_ext;
   logic [CMP_LEN_W-1:0] entry_len_clamped;
   logic [CMP_LEN_W-1:0] cmp_len;
   logic [ELEM_WIDTH-1:0] key_elem;
   logic [ELEM_WIDTH-1:0] entry_elem;

   always_comb begin
      entry_len_ext     = CMP_LEN_W'(entry_len);
      entry_len_clamped = (entry_len_ext > MAX_LEN) ? MAX_LEN : entry_len_ext;
      cmp_len           = (key_len < entry_len_clamped) ? key_len : entry_len_clamped;
      result            = '0;
      key_elem          = '0;
      entry_elem        = '0;
      // lowest differing element decides, so walk from the top down
      for (int i = CMP_ELEMS - 1; i >= 0; i--) begin
         key_elem   = key_elems[i*ELEM_WIDTH +: ELEM_WIDTH];
         entry_elem = entry_elems[i*ELEM_WIDTH +: ELEM_WIDTH];
         if (CMP_LEN_W'(i) < cmp_len && key_elem != entry_elem) begin
            result.key_below = (key_elem < entry_elem);
            result.key_above = (key_elem > entry_elem);
         end
      end
   end

endmodule

`default_nettype wire
